// ===== hw/rtl/fvc_pkg.sv =====
// Package: shared constants, register codes, state and control types for the forest vote block.
package fvc_pkg;

  localparam int unsigned CLASS_W = 6;
  localparam int unsigned VOTE_W = 7;
  localparam int unsigned Q_W = 25;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned NUM_CLASSES_DEFAULT = 39;
  localparam int unsigned NUM_TREES_DEFAULT = 100;

  localparam logic [Q_W-1:0] ONE_Q24 = 25'h100_0000;
  localparam logic [VOTE_W-1:0] TALLY_MAX = 7'd127;
  localparam logic [Q_W-1:0] EMA_WEIGHT_RESET = 25'd16777;
  localparam logic [Q_W-1:0] CONF_FLOOR_RESET = 25'd15099494;

  typedef enum logic [1:0] {
    REG_EMA_WEIGHT = 2'd0,
    REG_CONF_FLOOR = 2'd1,
    REG_VOTE_SCALE = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PROB,
    ST_MIX,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [Q_W-1:0] ema_weight;
    logic [Q_W-1:0] confidence_floor;
    logic [Q_W-1:0] vote_scale;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic upd;
    logic clr;
  } tally_ctl_t;

  typedef struct packed {
    logic restart;
    logic prob;
    logic mix;
    logic sum;
    logic emit;
  } conf_ctl_t;

endpackage

// ===== hw/rtl/fvc_regs.sv =====
// Configuration registers behind the APB port.
module fvc_regs #(
  parameter logic [fvc_pkg::Q_W-1:0] SCALE_RESET =
    fvc_pkg::Q_W'((1 << fvc_pkg::FRAC_W) / fvc_pkg::NUM_TREES_DEFAULT)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fvc_pkg::ADDR_W-1:0]      paddr,
  input  logic [fvc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fvc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output fvc_pkg::cfg_t                   cfg
);

  fvc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = fvc_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ema_weight       <= fvc_pkg::EMA_WEIGHT_RESET;
      cfg.confidence_floor <= fvc_pkg::CONF_FLOOR_RESET;
      cfg.vote_scale       <= SCALE_RESET;
    end else if (wr) begin
      unique case (idx)
        fvc_pkg::REG_EMA_WEIGHT: cfg.ema_weight <= pwdata[fvc_pkg::Q_W-1:0];
        fvc_pkg::REG_CONF_FLOOR: cfg.confidence_floor <= pwdata[fvc_pkg::Q_W-1:0];
        fvc_pkg::REG_VOTE_SCALE: cfg.vote_scale <= pwdata[fvc_pkg::Q_W-1:0];
        fvc_pkg::REG_NONE: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fvc_pkg::REG_EMA_WEIGHT: prdata = 32'(cfg.ema_weight);
      fvc_pkg::REG_CONF_FLOOR: prdata = 32'(cfg.confidence_floor);
      fvc_pkg::REG_VOTE_SCALE: prdata = 32'(cfg.vote_scale);
      fvc_pkg::REG_NONE:       prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/fvc_tally.sv =====
// Per-class tally memory with read-modify-write update and running best tracking.
module fvc_tally #(
  parameter int unsigned NUM_CLASSES = fvc_pkg::NUM_CLASSES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fvc_pkg::tally_ctl_t            ctl,
  input  logic [fvc_pkg::CLASS_W-1:0]    cls,
  output logic [fvc_pkg::VOTE_W-1:0]     best_votes,
  output logic [fvc_pkg::CLASS_W-1:0]    best_class
);

  localparam int unsigned IDX_W = $clog2(NUM_CLASSES);

  logic [fvc_pkg::VOTE_W-1:0]  mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]      valid;
  logic [fvc_pkg::VOTE_W-1:0]  rd_data;
  logic                        rd_valid;
  logic [fvc_pkg::CLASS_W-1:0] cls_q;
  logic                        in_range;
  logic                        in_range_q;
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            wr_idx;
  logic [fvc_pkg::VOTE_W-1:0]  cur;
  logic [fvc_pkg::VOTE_W-1:0]  cnt;
  logic                        wr_en;
  logic                        take;

  assign in_range = 7'(cls) < 7'(NUM_CLASSES);
  assign rd_idx   = cls[IDX_W-1:0];
  assign wr_idx   = cls_q[IDX_W-1:0];
  assign cur      = rd_valid ? rd_data : '0;
  assign cnt      = (cur < fvc_pkg::TALLY_MAX) ? cur + 7'd1 : cur;
  assign wr_en    = ctl.upd && in_range_q;
  assign take     = (cnt > best_votes) ||
                    ((cnt == best_votes) && (cnt != '0) && (cls_q < best_class));

  always_ff @(posedge clk) begin
    if (ctl.rd_en && in_range) begin
      rd_data <= mem[rd_idx];
    end
    if (wr_en) begin
      mem[wr_idx] <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      cls_q <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid   <= 1'b0;
      in_range_q <= 1'b0;
      best_votes <= '0;
      best_class <= '0;
    end else begin
      if (ctl.rd_en) begin
        in_range_q <= in_range;
        rd_valid   <= in_range && valid[rd_idx];
      end
      if (ctl.clr) begin
        valid      <= '0;
        best_votes <= '0;
        best_class <= '0;
      end else if (wr_en) begin
        valid[wr_idx] <= 1'b1;
        if (take) begin
          best_votes <= cnt;
          best_class <= cls_q;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fvc_conf.sv =====
// Confidence moving average, floor compare and saturating low-confidence counter.
module fvc_conf (
  input  logic                          clk,
  input  logic                          rst,
  input  fvc_pkg::conf_ctl_t            ctl,
  input  fvc_pkg::cfg_t                 cfg,
  input  logic [fvc_pkg::VOTE_W-1:0]    best_votes,
  output logic [fvc_pkg::Q_W-1:0]       conf_acc,
  output logic                          below,
  output logic [fvc_pkg::COUNT_W-1:0]   count_next
);

  logic [fvc_pkg::COUNT_W-1:0] count;
  logic [31:0]                 prob_raw;
  logic [fvc_pkg::Q_W-1:0]     prob_q;
  logic [fvc_pkg::Q_W-1:0]     w_q;
  logic [49:0]                 keep_q;
  logic [49:0]                 fresh_q;
  logic [50:0]                 sum;

  assign prob_raw = 32'(best_votes) * 32'(cfg.vote_scale);
  assign sum      = 51'(keep_q) + 51'(fresh_q);
  assign below    = conf_acc < cfg.confidence_floor;

  always_comb begin
    count_next = count;
    if (below && (count != '1)) begin
      count_next = count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prob) begin
      prob_q <= (prob_raw > 32'(fvc_pkg::ONE_Q24)) ? fvc_pkg::ONE_Q24 : prob_raw[24:0];
      w_q    <= (cfg.ema_weight > fvc_pkg::ONE_Q24) ? fvc_pkg::ONE_Q24 : cfg.ema_weight;
    end
    if (ctl.mix) begin
      keep_q  <= 50'(fvc_pkg::ONE_Q24 - w_q) * 50'(conf_acc);
      fresh_q <= 50'(w_q) * 50'(prob_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_acc <= fvc_pkg::ONE_Q24;
      count    <= '0;
    end else if (ctl.restart) begin
      conf_acc <= fvc_pkg::ONE_Q24;
      count    <= '0;
    end else begin
      if (ctl.sum) begin
        conf_acc <= sum[48:24];
      end
      if (ctl.emit) begin
        count <= count_next;
      end
    end
  end

endmodule

// ===== hw/rtl/forest_vote_with_confidence.sv =====
// Top level: vote intake, flow sequencer and result register of the forest vote block.
// A vote without the last mark goes through accept, then tally read-modify-write.
// A vote with the last mark goes through accept, tally update, probability multiply,
// mix multiplies, sum, result load; the result shows in the cycle after the result load,
// and the result load waits while the previous result is not yet taken. A new vote is
// taken only in idle, once the steps for the previous vote are done.
// Reset (rst, synchronous) clears tallies via valid bits, confidence to 1.0, counter to 0.
module forest_vote_with_confidence #(
  parameter int unsigned NUM_CLASSES = fvc_pkg::NUM_CLASSES_DEFAULT,
  parameter int unsigned NUM_TREES   = fvc_pkg::NUM_TREES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fvc_pkg::IN_DATA_W-1:0]     s_tdata,   // [5:0] tree_class
  input  logic                              s_tlast,   // last_vote
  input  logic                              s_tuser,   // [0] restart_run
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [5:0] winning_class, [12:6] winning_votes, [37:13] confidence_level,
  // [38] below_floor, [70:39] retrain_count
  output logic [fvc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fvc_pkg::ADDR_W-1:0]        paddr,
  input  logic [fvc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fvc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam logic [fvc_pkg::Q_W-1:0] SCALE_RESET = 25'((1 << 24) / NUM_TREES);

  fvc_pkg::state_t                state;
  fvc_pkg::state_t                state_next;
  fvc_pkg::cfg_t                  cfg;
  fvc_pkg::tally_ctl_t            tally_ctl;
  fvc_pkg::conf_ctl_t             conf_ctl;
  logic                           accept;
  logic                           last_q;
  logic                           slot_free;
  logic [fvc_pkg::VOTE_W-1:0]     best_votes;
  logic [fvc_pkg::CLASS_W-1:0]    best_class;
  logic [fvc_pkg::Q_W-1:0]        conf_acc;
  logic                           below;
  logic [fvc_pkg::COUNT_W-1:0]    count_next;

  fvc_regs #(
    .SCALE_RESET(SCALE_RESET)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  fvc_tally #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tally_ctl),
    .cls       (s_tdata[fvc_pkg::CLASS_W-1:0]),
    .best_votes(best_votes),
    .best_class(best_class)
  );

  fvc_conf u_conf (
    .clk       (clk),
    .rst       (rst),
    .ctl       (conf_ctl),
    .cfg       (cfg),
    .best_votes(best_votes),
    .conf_acc  (conf_acc),
    .below     (below),
    .count_next(count_next)
  );

  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= s_tlast;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fvc_pkg::ST_IDLE:   if (s_tvalid) state_next = fvc_pkg::ST_UPDATE;
      fvc_pkg::ST_UPDATE: state_next = last_q ? fvc_pkg::ST_PROB : fvc_pkg::ST_IDLE;
      fvc_pkg::ST_PROB:   state_next = fvc_pkg::ST_MIX;
      fvc_pkg::ST_MIX:    state_next = fvc_pkg::ST_SUM;
      fvc_pkg::ST_SUM:    state_next = fvc_pkg::ST_EMIT;
      fvc_pkg::ST_EMIT:   if (slot_free) state_next = fvc_pkg::ST_IDLE;
      default:            state_next = fvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = (state == fvc_pkg::ST_IDLE);
    tally_ctl.rd_en  = s_tvalid && (state == fvc_pkg::ST_IDLE);
    tally_ctl.upd    = (state == fvc_pkg::ST_UPDATE);
    tally_ctl.clr    = (state == fvc_pkg::ST_EMIT) && slot_free;
    conf_ctl.restart = s_tvalid && (state == fvc_pkg::ST_IDLE) && s_tuser;
    conf_ctl.prob    = (state == fvc_pkg::ST_PROB);
    conf_ctl.mix     = (state == fvc_pkg::ST_MIX);
    conf_ctl.sum     = (state == fvc_pkg::ST_SUM);
    conf_ctl.emit    = (state == fvc_pkg::ST_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (conf_ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (conf_ctl.emit) begin
      m_tdata <= {1'b0, count_next, below, conf_acc, best_votes, best_class};
    end
  end

`ifndef ASSERT_OFF
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == fvc_pkg::ST_EMIT))
    else $error("result appeared without a flow close");

  a_conf_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:13] <= fvc_pkg::ONE_Q24))
    else $error("confidence above 1.0");

  a_below_counts: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[38]) |-> (m_tdata[70:39] != '0))
    else $error("low confidence flow not counted");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != fvc_pkg::ST_IDLE) |-> !tally_ctl.rd_en)
    else $error("tally read issued during an update");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for forest_vote_with_confidence: directed table, random flows, predictor check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_CLASSES = fvc_pkg::NUM_CLASSES_DEFAULT;
  localparam int unsigned N_TREES = fvc_pkg::NUM_TREES_DEFAULT;
  localparam int unsigned N_DIRECTED = 17;

  typedef struct packed {
    logic [fvc_pkg::CLASS_W-1:0] cls;
    logic                        last;
    logic                        restart;
    logic                        typed;
    logic [fvc_pkg::CLASS_W-1:0] t_class;
    logic [fvc_pkg::VOTE_W-1:0]  t_votes;
  } vote_row_t;

  typedef struct packed {
    logic [fvc_pkg::CLASS_W-1:0] cls;
    logic [fvc_pkg::VOTE_W-1:0]  votes;
    logic [fvc_pkg::Q_W-1:0]     conf;
    logic                        below;
    logic [fvc_pkg::COUNT_W-1:0] retrain;
  } flow_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [fvc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tlast = 1'b0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [fvc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [fvc_pkg::ADDR_W-1:0]     paddr = '0;
  logic [fvc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [fvc_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  forest_vote_with_confidence u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [5:0] tree_class
    .s_tlast  (s_tlast),   // last_vote
    .s_tuser  (s_tuser),   // [0] restart_run
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    // [5:0] winning_class, [12:6] winning_votes, [37:13] confidence_level,
    // [38] below_floor, [70:39] retrain_count
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [fvc_pkg::VOTE_W-1:0]  tally [N_CLASSES];
  logic [fvc_pkg::VOTE_W-1:0]  lead_votes = '0;
  logic [fvc_pkg::CLASS_W-1:0] lead_class = '0;
  logic [fvc_pkg::Q_W-1:0]     conf_acc = fvc_pkg::ONE_Q24;
  logic [fvc_pkg::COUNT_W-1:0] low_flows = '0;
  logic [fvc_pkg::Q_W-1:0]     cfg_weight = fvc_pkg::EMA_WEIGHT_RESET;
  logic [fvc_pkg::Q_W-1:0]     cfg_floor = fvc_pkg::CONF_FLOOR_RESET;
  logic [fvc_pkg::Q_W-1:0]     cfg_scale = fvc_pkg::Q_W'(32'(fvc_pkg::ONE_Q24) / N_TREES);

  flow_result_t flow_verdicts [$];
  int  mismatches = 0;
  bit  send_tight = 1'b0;
  bit  recv_tight = 1'b0;
  bit  hold_req = 1'b0;

  vote_row_t directed_rows [N_DIRECTED] = '{
    '{6'd0,  1'b1, 1'b0, 1'b1, 6'd0,  7'd1},
    '{6'd63, 1'b1, 1'b0, 1'b1, 6'd0,  7'd0},
    '{6'd38, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd38, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd2,  1'b1, 1'b0, 1'b1, 6'd38, 7'd2},
    '{6'd7,  1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd3,  1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd7,  1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd3,  1'b1, 1'b0, 1'b1, 6'd3,  7'd2},
    '{6'd1,  1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd39, 1'b1, 1'b0, 1'b1, 6'd1,  7'd1},
    '{6'd4,  1'b0, 1'b1, 1'b0, 6'd0,  7'd0},
    '{6'd4,  1'b1, 1'b0, 1'b1, 6'd4,  7'd2},
    '{6'd10, 1'b1, 1'b1, 1'b1, 6'd10, 7'd1},
    '{6'd22, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd21, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},
    '{6'd20, 1'b1, 1'b0, 1'b1, 6'd20, 7'd1}
  };

  initial begin
    foreach (tally[i]) tally[i] = '0;
  end

  function automatic bit tally_vote(input logic [fvc_pkg::CLASS_W-1:0] cls, input logic last,
                                    input logic restart, output flow_result_t r);
    logic [fvc_pkg::VOTE_W-1:0] c;
    logic [63:0] w;
    logic [63:0] prob;
    logic [63:0] mix;
    logic below;
    r = '0;
    if (restart) begin
      conf_acc = fvc_pkg::ONE_Q24;
      low_flows = '0;
    end
    if (32'(cls) < N_CLASSES) begin
      c = tally[cls];
      if (c < fvc_pkg::TALLY_MAX) c = c + 1'b1;
      tally[cls] = c;
      if (c > lead_votes || (c == lead_votes && c != 0 && cls < lead_class)) begin
        lead_votes = c;
        lead_class = cls;
      end
    end
    if (!last) return 1'b0;
    w = (cfg_weight > fvc_pkg::ONE_Q24) ? 64'(fvc_pkg::ONE_Q24) : 64'(cfg_weight);
    prob = 64'(lead_votes) * 64'(cfg_scale);
    if (prob > 64'(fvc_pkg::ONE_Q24)) prob = 64'(fvc_pkg::ONE_Q24);
    mix = ((64'(fvc_pkg::ONE_Q24) - w) * 64'(conf_acc) + w * prob) >> fvc_pkg::FRAC_W;
    conf_acc = mix[fvc_pkg::Q_W-1:0];
    below = (conf_acc < cfg_floor);
    if (below && low_flows != '1) low_flows = low_flows + 1'b1;
    r.cls = lead_class;
    r.votes = lead_votes;
    r.conf = conf_acc;
    r.below = below;
    r.retrain = low_flows;
    foreach (tally[i]) tally[i] = '0;
    lead_votes = '0;
    lead_class = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input longint unsigned exp_v,
                             input longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
      mismatches++;
    end
  endtask

  task automatic send_vote(input vote_row_t row);
    int gap;
    flow_result_t r;
    @(negedge clk);
    if ($urandom_range(0, 31) == 0) send_tight = !send_tight;
    gap = send_tight ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, row.cls};
    s_tlast <= row.last;
    s_tuser <= row.restart;
    do @(posedge clk); while (!s_tready);
    if (tally_vote(row.cls, row.last, row.restart, r)) begin
      if (row.typed) begin
        r.cls = row.t_class;
        r.votes = row.t_votes;
      end
      flow_verdicts.push_back(r);
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic settle(input int extra);
    while (flow_verdicts.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_read(input fvc_pkg::reg_idx_t idx, input logic [fvc_pkg::Q_W-1:0] exp_v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", 64'(exp_v), 64'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input fvc_pkg::reg_idx_t idx, input logic [fvc_pkg::Q_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      fvc_pkg::REG_EMA_WEIGHT: cfg_weight = v;
      fvc_pkg::REG_CONF_FLOOR: cfg_floor = v;
      fvc_pkg::REG_VOTE_SCALE: cfg_scale = v;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_read(idx, v);
  endtask

  task automatic run_flows(input int budget, input bit with_long);
    int sent;
    int len;
    int fav;
    int pick;
    vote_row_t row;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      fav = $urandom_range(0, N_CLASSES - 1);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 15);
        row = '0;
        if (pick <= 8) row.cls = fvc_pkg::CLASS_W'(fav);
        else if (pick <= 13) row.cls = fvc_pkg::CLASS_W'($urandom_range(0, N_CLASSES - 1));
        else if (pick == 14) row.cls = fvc_pkg::CLASS_W'($urandom_range(N_CLASSES, 63));
        else row.cls = $urandom_range(0, 1) ? fvc_pkg::CLASS_W'(N_CLASSES - 1) : '0;
        row.restart = ($urandom_range(0, 59) == 0);
        row.last = (i == len - 1);
        send_vote(row);
      end
      sent += len;
    end
    if (with_long) begin
      len = $urandom_range(128, 136);
      fav = $urandom_range(0, N_CLASSES - 1);
      for (int i = 0; i < len; i++) begin
        row = '0;
        row.cls = ($urandom_range(0, 9) == 0) ? fvc_pkg::CLASS_W'($urandom_range(0, 63))
                                              : fvc_pkg::CLASS_W'(fav);
        row.last = (i == len - 1);
        send_vote(row);
      end
    end
  endtask

  always @(posedge clk) begin
    flow_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (flow_verdicts.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, m_tdata);
        mismatches++;
      end else begin
        e = flow_verdicts.pop_front();
        check_field("winning_class", 64'(e.cls), 64'(m_tdata[5:0]));
        check_field("winning_votes", 64'(e.votes), 64'(m_tdata[12:6]));
        check_field("confidence_level", 64'(e.conf), 64'(m_tdata[37:13]));
        check_field("below_floor", 64'(e.below), 64'(m_tdata[38]));
        check_field("retrain_count", 64'(e.retrain), 64'(m_tdata[70:39]));
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) recv_tight = !recv_tight;
      if (hold_req) begin
        stall = 400;
        hold_req = 1'b0;
      end else begin
        stall = recv_tight ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    cfg_read(fvc_pkg::REG_EMA_WEIGHT, fvc_pkg::EMA_WEIGHT_RESET);
    cfg_read(fvc_pkg::REG_CONF_FLOOR, fvc_pkg::CONF_FLOOR_RESET);
    cfg_read(fvc_pkg::REG_VOTE_SCALE, fvc_pkg::Q_W'(32'(fvc_pkg::ONE_Q24) / N_TREES));
    for (int i = 0; i < N_DIRECTED; i++) send_vote(directed_rows[i]);
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        idle_input();
        settle(10);
        case (p)
          1: begin
            cfg_write(fvc_pkg::REG_EMA_WEIGHT, fvc_pkg::ONE_Q24);
            cfg_write(fvc_pkg::REG_CONF_FLOOR, fvc_pkg::ONE_Q24);
            cfg_write(fvc_pkg::REG_VOTE_SCALE, fvc_pkg::ONE_Q24);
          end
          2: begin
            cfg_write(fvc_pkg::REG_EMA_WEIGHT, '0);
            cfg_write(fvc_pkg::REG_CONF_FLOOR, '0);
            cfg_write(fvc_pkg::REG_VOTE_SCALE, '0);
          end
          3: begin
            cfg_write(fvc_pkg::REG_EMA_WEIGHT, '1);
            cfg_write(fvc_pkg::REG_CONF_FLOOR, '1);
            cfg_write(fvc_pkg::REG_VOTE_SCALE, '1);
          end
          4: begin
            cfg_write(fvc_pkg::REG_EMA_WEIGHT,
                      fvc_pkg::Q_W'($urandom_range(0, 32'(fvc_pkg::ONE_Q24))));
            cfg_write(fvc_pkg::REG_CONF_FLOOR,
                      fvc_pkg::Q_W'($urandom_range(32'(fvc_pkg::ONE_Q24) / 2,
                                                   32'(fvc_pkg::ONE_Q24))));
            cfg_write(fvc_pkg::REG_VOTE_SCALE, fvc_pkg::Q_W'($urandom_range(0, 1 << 20)));
          end
          default: begin
            cfg_write(fvc_pkg::REG_EMA_WEIGHT,
                      fvc_pkg::Q_W'($urandom_range(1 << 18, 1 << 23)));
            cfg_write(fvc_pkg::REG_CONF_FLOOR,
                      fvc_pkg::Q_W'($urandom_range(32'(fvc_pkg::ONE_Q24) - (1 << 21),
                                                   32'(fvc_pkg::ONE_Q24))));
            cfg_write(fvc_pkg::REG_VOTE_SCALE,
                      fvc_pkg::Q_W'(32'(fvc_pkg::ONE_Q24) / N_TREES));
          end
        endcase
      end
      if (p == 2) hold_req = 1'b1;
      run_flows(140, p == 1 || p == 3);
    end
    idle_input();
    settle(20);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fvc_pkg.sv
hw/rtl/fvc_regs.sv
hw/rtl/fvc_tally.sv
hw/rtl/fvc_conf.sv
hw/rtl/forest_vote_with_confidence.sv
bench/tb_top.sv
